>>> sv/idm_pkg.sv
`timescale 1ns / 1ps

package idm_pkg;

	// Port widths are fixed; the arithmetic width is a top-level parameter.
	localparam int DATA_BITS = 64;
	localparam int OP_BITS   = 2;

	typedef enum logic [OP_BITS-1:0] {
		OP_UDIV = 2'd0,
		OP_UREM = 2'd1,
		OP_SDIV = 2'd2,
		OP_SREM = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_DIVIDE = 2'd1,
		ST_FIX    = 2'd2
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic res_stall;
	} stat_t;

endpackage

>>> sv/idm_if.sv
`timescale 1ns / 1ps

interface idm_req_if;
	import idm_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [OP_BITS-1:0]   opcode;
	logic [DATA_BITS-1:0] dividend;
	logic [DATA_BITS-1:0] divisor;

	modport source (output valid, output opcode, output dividend, output divisor, input ready);
	modport sink (input valid, input opcode, input dividend, input divisor, output ready);
endinterface

interface idm_rsp_if;
	import idm_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [DATA_BITS-1:0] result;

	modport source (output valid, output result, input ready);
	modport sink (input valid, input result, output ready);
endinterface

>>> sv/idm_dpath.sv
`timescale 1ns / 1ps

module idm_dpath #(
	parameter int DATA_WIDTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  idm_pkg::cmd_t                 cmd,
	output idm_pkg::stat_t                stat,
	input  logic [idm_pkg::OP_BITS-1:0]   opcode,
	input  logic [idm_pkg::DATA_BITS-1:0] dividend,
	input  logic [idm_pkg::DATA_BITS-1:0] divisor,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [idm_pkg::DATA_BITS-1:0] result
);
	import idm_pkg::*;

	localparam int DW = DATA_WIDTH;

	op_t           op_in;
	logic          op_signed;
	logic          sa;
	logic          sb;
	logic [DW-1:0] a_in;
	logic [DW-1:0] b_in;
	logic [DW-1:0] a_mag;
	logic [DW-1:0] b_mag;

	op_t           op_q;
	logic          neg_quo_q;
	logic          neg_rem_q;
	logic          zero_q;
	logic [DW-1:0] div_q;
	logic [DW-1:0] part_q;
	logic [DW-1:0] quo_q;

	logic          carry;
	logic [DW-1:0] shifted;
	logic [DW:0]   diff;
	logic          take;
	logic [DW-1:0] part_nx;
	logic [DW-1:0] quo_nx;
	logic [DW-1:0] res_fix;

	logic [DATA_BITS-1:0] res_q;
	logic                 res_valid_q;

	// Operand capture: drop the bits above the datapath width, take magnitudes
	assign op_in     = op_t'(opcode);
	assign op_signed = (op_in == OP_SDIV) || (op_in == OP_SREM);
	assign a_in      = dividend[DW-1:0];
	assign b_in      = divisor[DW-1:0];
	assign sa        = op_signed & a_in[DW-1];
	assign sb        = op_signed & b_in[DW-1];
	assign a_mag     = sa ? (DW'(0) - a_in) : a_in;
	assign b_mag     = sb ? (DW'(0) - b_in) : b_in;

	// One restoring step: shift the next dividend bit in, subtract if it fits
	assign carry   = part_q[DW-1];
	assign shifted = {part_q[DW-2:0], quo_q[DW-1]};
	assign diff    = {carry, shifted} - {1'b0, div_q};
	assign take    = carry | ~diff[DW];
	assign part_nx = take ? diff[DW-1:0] : shifted;
	assign quo_nx  = {quo_q[DW-2:0], take};

	always_comb begin
		res_fix = quo_q;
		case (op_q)
			OP_UDIV: res_fix = quo_q;
			OP_UREM: res_fix = part_q;
			OP_SDIV: res_fix = neg_quo_q ? (DW'(0) - quo_q) : quo_q;
			OP_SREM: res_fix = neg_rem_q ? (DW'(0) - part_q) : part_q;
			default: res_fix = quo_q;
		endcase
		if (zero_q) begin
			res_fix = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= op_in;
			neg_quo_q <= sa ^ sb;
			neg_rem_q <= sa;
			zero_q    <= (b_in == '0);
			div_q     <= b_mag;
			part_q    <= '0;
			quo_q     <= a_mag;
		end else if (cmd.step) begin
			part_q <= part_nx;
			quo_q  <= quo_nx;
		end
		if (cmd.finish) begin
			res_q <= DATA_BITS'(res_fix);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			res_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign stat.res_stall = res_valid_q & ~rsp_ready;
	assign rsp_valid      = res_valid_q;
	assign result         = res_q;

endmodule

>>> sv/idm_ctrl.sv
`timescale 1ns / 1ps

module idm_ctrl #(
	parameter int DATA_WIDTH = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  idm_pkg::stat_t stat,
	output idm_pkg::cmd_t  cmd
);
	import idm_pkg::*;

	localparam int CntW = $clog2(DATA_WIDTH);

	state_t          state_q;
	state_t          state_d;
	logic [CntW-1:0] cnt_q;
	logic [CntW-1:0] cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		req_ready  = 1'b0;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					cnt_d    = CntW'(DATA_WIDTH - 1);
					state_d  = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				cmd.step = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_FIX;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_FIX: begin
				// hold while the previous result is still waiting
				if (!stat.res_stall) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> sv/int64_divide_modulo.sv
`timescale 1ns / 1ps
// Channel  Modport  Payload                        Direction
// req      sink     opcode[1:0], dividend, divisor  request in
// rsp      source   result                          response out
//
// Each request runs through operand capture, where magnitudes are taken, DATA_WIDTH
// passes through the single shared subtractor (one quotient bit a pass), and a
// sign fix into the result register. Reset returns the controller to idle and
// empties the result slot. A new request is taken as soon as the result register
// is written; the sign fix step holds while an earlier result is still waiting
// on rsp.

module int64_divide_modulo #(
	parameter int DATA_WIDTH = 64
) (
	input logic     clk,
	input logic     arst_n,
	idm_req_if.sink req,
	idm_rsp_if.source rsp
);
	import idm_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Sequencer: accept, iterate, fix sign
	idm_ctrl #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Operand registers, shift-and-subtract step and result register
	idm_dpath #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.opcode   (req.opcode),
		.dividend (req.dividend),
		.divisor  (req.divisor),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.result   (rsp.result)
	);

`ifndef SYNTHESIS
	// The divider is busy straight after taking a request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while divider busy");

	// Never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !stat.res_stall)
		else $error("result register overwritten while held");

	// Iteration never overlaps with operand capture
	a_step_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !req.ready)
		else $error("input ready during iteration");

	// At most one datapath command a cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.step, cmd.finish}))
		else $error("conflicting datapath commands");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import idm_pkg::*;

	// Arithmetic width of the unit under test; ports stay DATA_BITS wide.
	localparam int DW          = 64;
	localparam int RANDOM_ITEMS = 850;
	// Slowest legal run: ~875 requests, each a full divide plus long
	// sender gaps and receiver stalls; taken several times over.
	localparam int CYCLE_LIMIT = 900000;
	// Cycles to watch for stray results once everything has been checked.
	localparam int TAIL_CYCLES = 80;

	typedef struct {
		op_t         opcode;
		logic [63:0] dividend;
		logic [63:0] divisor;
		bit          after_drain; // hold this request until the unit is empty
	} div_req_t;

	logic clk;
	logic arst_n;

	idm_req_if req_ch ();
	idm_rsp_if rsp_ch ();

	int64_divide_modulo #(
		.DATA_WIDTH(DW)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch.sink),
		.rsp   (rsp_ch.source)
	);

	div_req_t    pending_reqs[$];
	logic [63:0] expected_results[$];

	int n_total;
	int n_accepted;
	int n_checked;
	int n_errors;
	int cycle_count;

	// Quotient or remainder exactly as the unit must produce it: restoring
	// division on magnitudes, sign fixed afterwards, negations wrapping.
	function automatic logic [63:0] divmod_expect(op_t op, logic [63:0] num_w,
			logic [63:0] den_w);
		logic [DW-1:0] num;
		logic [DW-1:0] den;
		logic [DW-1:0] quo;
		logic [DW-1:0] part;
		logic [DW-1:0] res;
		logic          carry;
		logic          neg_num;
		logic          neg_den;
		logic [63:0]   wide;
		num     = num_w[DW-1:0];
		den     = den_w[DW-1:0];
		quo     = '0;
		part    = '0;
		neg_num = 1'b0;
		neg_den = 1'b0;
		wide    = '0;
		// Zero divisor gives zero whatever the opcode
		if (den == '0)
			return '0;
		if (op == OP_SDIV || op == OP_SREM) begin
			neg_num = num[DW-1];
			neg_den = den[DW-1];
			if (neg_num)
				num = -num;
			if (neg_den)
				den = -den;
		end
		for (int i = DW - 1; i >= 0; i--) begin
			carry = part[DW-1];
			part  = {part[DW-2:0], num[i]};
			quo   = {quo[DW-2:0], 1'b0};
			if (carry || part >= den) begin
				part   = part - den;
				quo[0] = 1'b1;
			end
		end
		case (op)
			OP_UDIV: res = quo;
			OP_UREM: res = part;
			OP_SDIV: res = (neg_num != neg_den) ? -quo : quo;
			default: res = neg_num ? -part : part;
		endcase
		wide[DW-1:0] = res;
		return wide;
	endfunction

	// Operand with a spread of magnitudes, signs and corner values
	function automatic logic [63:0] shaped_word();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		case ($urandom_range(6))
			0: w = w >> $urandom_range(63);
			1: w = -(w >> $urandom_range(63));
			2: begin
				case ($urandom_range(4))
					0: w = 64'h8000_0000_0000_0000;
					1: w = '1;
					2: w = 64'd1;
					3: w = 64'h7fff_ffff_ffff_ffff;
					default: w = '0;
				endcase
			end
			default: ;
		endcase
		return w;
	endfunction

	function automatic void queue_req(op_t op, logic [63:0] a, logic [63:0] b, bit drain);
		div_req_t r;
		r.opcode      = op;
		r.dividend    = a;
		r.divisor     = b;
		r.after_drain = drain;
		pending_reqs.push_back(r);
	endfunction

	// Idle percentages: sender light / receiver heavy, then swapped, then none
	function automatic int send_idle_pct(int done_cnt);
		if (done_cnt < n_total / 3)
			return 21;
		if (done_cnt < (2 * n_total) / 3)
			return 74;
		return 0;
	endfunction

	function automatic int recv_idle_pct(int done_cnt);
		if (done_cnt < n_total / 3)
			return 74;
		if (done_cnt < (2 * n_total) / 3)
			return 21;
		return 0;
	endfunction

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// Driver: present the head of the pending queue, hold it until accepted,
	// and record the expected result on acceptance.
	always @(posedge clk or negedge arst_n) begin
		bit fire;
		int sent_now;
		div_req_t head;
		if (!arst_n) begin
			req_ch.valid    <= 1'b0;
			req_ch.opcode   <= '0;
			req_ch.dividend <= '0;
			req_ch.divisor  <= '0;
			n_accepted      <= 0;
		end else begin
			fire     = req_ch.valid && req_ch.ready;
			sent_now = n_accepted;
			if (fire) begin
				head = pending_reqs.pop_front();
				expected_results.push_back(divmod_expect(head.opcode, head.dividend,
					head.divisor));
				sent_now   = n_accepted + 1;
				n_accepted <= sent_now;
			end
			// Hold a request that is still waiting; otherwise pick the next one
			if (!(req_ch.valid && !fire)) begin
				if (pending_reqs.size() > 0
						&& !(pending_reqs[0].after_drain && sent_now != n_checked)
						&& $urandom_range(99) >= send_idle_pct(sent_now)) begin
					req_ch.valid    <= 1'b1;
					req_ch.opcode   <= pending_reqs[0].opcode;
					req_ch.dividend <= pending_reqs[0].dividend;
					req_ch.divisor  <= pending_reqs[0].divisor;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted result against the oldest expectation and
	// throttle ready at random.
	always @(posedge clk or negedge arst_n) begin
		logic [63:0] want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			n_checked    <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("result: none expected, actual %h", rsp_ch.result);
					n_errors = n_errors + 1;
				end else begin
					want = expected_results.pop_front();
					if (rsp_ch.result !== want) begin
						$error("result mismatch: expected %h, actual %h", want,
							rsp_ch.result);
						n_errors = n_errors + 1;
					end
					n_checked <= n_checked + 1;
				end
			end
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct(n_accepted));
		end
	end

	initial begin
		logic [63:0] a;
		logic [63:0] b;
		op_t         op;
		clk             = 1'b0;
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.opcode   = '0;
		req_ch.dividend = '0;
		req_ch.divisor  = '0;
		rsp_ch.ready    = 1'b0;
		n_errors        = 0;
		cycle_count     = 0;

		// Directed: zero divisor on every opcode
		queue_req(OP_UDIV, 64'd12345, '0, 1'b0);
		queue_req(OP_UREM, '1, '0, 1'b0);
		queue_req(OP_SDIV, 64'h8000_0000_0000_0000, '0, 1'b0);
		queue_req(OP_SREM, '1, '0, 1'b0);
		// Extremes of the unsigned path
		queue_req(OP_UDIV, '1, 64'd1, 1'b0);
		queue_req(OP_UREM, '1, '1, 1'b0);
		queue_req(OP_UDIV, '1, 64'h8000_0000_0000_0000, 1'b0);
		queue_req(OP_UREM, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 1'b0);
		queue_req(OP_UDIV, '0, '1, 1'b0);
		queue_req(OP_UDIV, 64'd5, 64'd7, 1'b0);
		// Most negative over minus one: quotient wraps, remainder zero
		queue_req(OP_SDIV, 64'h8000_0000_0000_0000, '1, 1'b0);
		queue_req(OP_SREM, 64'h8000_0000_0000_0000, '1, 1'b0);
		queue_req(OP_SDIV, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b0);
		queue_req(OP_SREM, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 1'b0);
		queue_req(OP_SDIV, 64'h8000_0000_0000_0000, 64'd1, 1'b0);
		// Sign combinations on both signed opcodes
		queue_req(OP_SDIV, -64'sd7, 64'd2, 1'b0);
		queue_req(OP_SDIV, 64'd7, -64'sd2, 1'b0);
		queue_req(OP_SDIV, -64'sd7, -64'sd2, 1'b0);
		queue_req(OP_SREM, -64'sd7, 64'd2, 1'b0);
		queue_req(OP_SREM, 64'd7, -64'sd2, 1'b0);
		queue_req(OP_SREM, -64'sd7, -64'sd2, 1'b0);
		queue_req(OP_SDIV, 64'h7fff_ffff_ffff_ffff, '1, 1'b0);
		queue_req(OP_UREM, 64'hdead_beef_cafe_f00d, 64'h0000_0001_0000_0003, 1'b0);

		// Random part; drain the unit before a handful of requests
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			op = op_t'($urandom_range(3));
			a  = shaped_word();
			b  = ($urandom_range(29) == 0) ? 64'd0 : shaped_word();
			queue_req(op, a, b, (i % 200) == 0);
		end
		n_total = pending_reqs.size();

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (!(n_accepted == n_total && n_checked == n_accepted
				&& expected_results.size() == 0) && cycle_count < CYCLE_LIMIT)
			@(posedge clk);

		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			// Watch for stray results before the verdict
			repeat (TAIL_CYCLES) @(posedge clk);
			if (n_errors == 0 && expected_results.size() == 0) begin
				$display("Test completed successfully");
			end else begin
				$display("Test completed with failures");
			end
			$finish;
		end
	end

endmodule
